// ===== design/rtlpm_pkg.sv =====
// Shared types, constants and helpers for the IPv4 longest-prefix-match route table.
// Used by the route memory and the top-level lookup sequencer; depends on nothing else.
package rtlpm_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned PLEN_W    = 6;
    localparam int unsigned TBL_W     = 32;
    localparam int unsigned MTU_W     = 16;
    localparam int unsigned IFX_W     = 16;
    localparam int unsigned HIT_IDX_W = 6;
    localparam int unsigned STATUS_W  = 2;

    // 167 bits of request fields, padded to whole bytes
    localparam int unsigned S_DATA_W = 168;
    // 102 bits of result fields, padded to whole bytes
    localparam int unsigned M_DATA_W = 104;

    localparam logic [PLEN_W-1:0] MAX_PLEN = 6'd32;

    // request kinds carried in s_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // result status carried in m_tuser
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic              usable;
        logic [IFX_W-1:0]  ifindex;
        logic [MTU_W-1:0]  mtu;
        logic [ADDR_W-1:0] gw;
        logic [ADDR_W-1:0] src;
        logic [TBL_W-1:0]  table_num;
        logic [PLEN_W-1:0] prefix;
        logic [ADDR_W-1:0] dest;
    } route_entry_t;

    // Network mask for a prefix length of 0..32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] mask;
        if (plen == '0) begin
            mask = '0;
        end else begin
            mask = {ADDR_W{1'b1}} << (MAX_PLEN - plen);
        end
        return mask;
    endfunction

endpackage

// ===== design/rtlpm_route_mem.sv =====
// Route entry storage: one write port and one registered read port.
// Depends on rtlpm_pkg for the entry layout.
module rtlpm_route_mem #(
    parameter int unsigned TABLE_DEPTH = rtlpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                                aclk,
    input  logic                                                wr_en,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
    input  rtlpm_pkg::route_entry_t                             wr_data,
    input  logic                                                rd_en,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
    output rtlpm_pkg::route_entry_t                             rd_data
);
    import rtlpm_pkg::*;

    route_entry_t mem [TABLE_DEPTH];
    route_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/route_table_longest_prefix_match_unit.sv =====
// IPv4 route table with longest-prefix-match lookup.
// Request stream on s_*: s_tuser selects insert or lookup, s_tdata holds the route
// fields. Result stream on m_*: m_tuser holds the status, m_tdata the matched entry.
// Every request gives exactly one result, in request order.
// An insert appends at the fill count, then goes from the insert state to the done
// state; an insert into a full table is refused with status full and the table
// is left as it was. A lookup reads the stored entries through the single read
// port of the route memory, one entry per cycle, and feeds them to one compare
// unit that keeps the best match (longest prefix, earliest entry on a tie); a hit
// then rereads the winning entry. A hit passes through the scan, find, fetch and
// done states; a miss skips the fetch state. s_tready is high only while the
// sequencer is idle, so one request is in work at a time and the next request
// can be taken in the cycle after the result is loaded. The result sits in an
// output register: the sequencer returns to idle and takes the next request while
// m_tvalid waits for m_tready; a second result waits in the sequencer until the
// output register is free.
// aresetn (synchronous, active low) empties the table and drops any pending
// result; the route memory itself is not cleared and needs no clearing pass.
module route_table_longest_prefix_match_unit #(
    parameter int unsigned TABLE_DEPTH = rtlpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // dest_addr, prefix_len, route_table, new_src_addr, new_gw_addr, new_mtu,
    // new_if_index, new_usable, zero pad
    input  logic [rtlpm_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit_index, hit_src_addr, hit_gw_addr, hit_mtu, hit_if_index, zero pad
    output logic [rtlpm_pkg::M_DATA_W-1:0]   m_tdata,
    // status
    output logic [rtlpm_pkg::STATUS_W-1:0]   m_tuser
);
    import rtlpm_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam int unsigned PAD_W = M_DATA_W - (HIT_IDX_W + 2 * ADDR_W + MTU_W + IFX_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INS   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FIND  = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] entry_cnt_reg, entry_cnt_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             found_reg, found_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // payload
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [PLEN_W-1:0]    best_len_reg, best_len_next;
    logic [ADDR_W-1:0]    req_addr_reg, req_addr_next;
    logic [PLEN_W-1:0]    req_plen_reg, req_plen_next;
    logic [TBL_W-1:0]     req_table_reg, req_table_next;
    logic [ADDR_W-1:0]    req_src_reg, req_src_next;
    logic [ADDR_W-1:0]    req_gw_reg, req_gw_next;
    logic [MTU_W-1:0]     req_mtu_reg, req_mtu_next;
    logic [IFX_W-1:0]     req_if_reg, req_if_next;
    logic                 req_usable_reg, req_usable_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [HIT_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [ADDR_W-1:0]    res_src_reg, res_src_next;
    logic [ADDR_W-1:0]    res_gw_reg, res_gw_next;
    logic [MTU_W-1:0]     res_mtu_reg, res_mtu_next;
    logic [IFX_W-1:0]     res_if_reg, res_if_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    logic             mem_wr_en;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    route_entry_t     wr_entry;
    route_entry_t     rd_entry;
    logic             scan_rd;
    logic             cmp_match;
    logic             cmp_better;
    logic [PLEN_W-1:0] ins_plen;

    rtlpm_route_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_route_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (entry_cnt_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_entry)
    );

    // build the stored form of an inserted route: saturated prefix, host bits cleared
    always_comb begin
        ins_plen           = (req_plen_reg > MAX_PLEN) ? MAX_PLEN : req_plen_reg;
        wr_entry.dest      = req_addr_reg & prefix_mask(ins_plen);
        wr_entry.prefix    = ins_plen;
        wr_entry.table_num = req_table_reg;
        wr_entry.src       = req_src_reg;
        wr_entry.gw        = req_gw_reg;
        wr_entry.mtu       = req_mtu_reg;
        wr_entry.ifindex   = req_if_reg;
        wr_entry.usable    = req_usable_reg;
    end

    // shared compare unit: one fetched entry per cycle against the lookup key
    assign cmp_match  = rd_vld_reg && rd_entry.usable
                        && (rd_entry.table_num == req_table_reg)
                        && (rd_entry.dest == (req_addr_reg & prefix_mask(rd_entry.prefix)));
    assign cmp_better = cmp_match && (!found_reg || (rd_entry.prefix > best_len_reg));

    assign scan_rd = (state_reg == ST_SCAN) && (scan_idx_reg < entry_cnt_reg);

    always_comb begin
        state_next      = state_reg;
        entry_cnt_next  = entry_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = scan_rd;
        rd_idx_next     = scan_idx_reg[IDX_W-1:0];
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_len_next   = best_len_reg;
        req_addr_next   = req_addr_reg;
        req_plen_next   = req_plen_reg;
        req_table_next  = req_table_reg;
        req_src_next    = req_src_reg;
        req_gw_next     = req_gw_reg;
        req_mtu_next    = req_mtu_reg;
        req_if_next     = req_if_reg;
        req_usable_next = req_usable_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_src_next    = res_src_reg;
        res_gw_next     = res_gw_reg;
        res_mtu_next    = res_mtu_reg;
        res_if_next     = res_if_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = scan_idx_reg[IDX_W-1:0];

        if (cmp_better) begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_len_next = rd_entry.prefix;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_addr_next   = s_tdata[31:0];
                    req_plen_next   = s_tdata[37:32];
                    req_table_next  = s_tdata[69:38];
                    req_src_next    = s_tdata[101:70];
                    req_gw_next     = s_tdata[133:102];
                    req_mtu_next    = s_tdata[149:134];
                    req_if_next     = s_tdata[165:150];
                    req_usable_next = s_tdata[166];
                    scan_idx_next   = '0;
                    found_next      = 1'b0;
                    state_next      = (s_tuser == REQ_INSERT) ? ST_INS : ST_SCAN;
                end
            end
            ST_INS: begin
                if (entry_cnt_reg == DEPTH_CNT) begin
                    res_status_next = STATUS_FULL;
                    res_idx_next    = '0;
                    res_src_next    = '0;
                    res_gw_next     = '0;
                    res_mtu_next    = '0;
                    res_if_next     = '0;
                end else begin
                    mem_wr_en       = 1'b1;
                    entry_cnt_next  = CNT_W'(entry_cnt_reg + 1'b1);
                    res_status_next = STATUS_OK;
                    res_idx_next    = HIT_IDX_W'(entry_cnt_reg);
                    res_src_next    = req_src_reg;
                    res_gw_next     = req_gw_reg;
                    res_mtu_next    = req_mtu_reg;
                    res_if_next     = req_if_reg;
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                mem_rd_en = scan_rd;
                if (scan_rd) begin
                    scan_idx_next = CNT_W'(scan_idx_reg + 1'b1);
                end else if (!rd_vld_reg) begin
                    // last compare has retired
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                if (found_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = best_idx_reg;
                    state_next  = ST_FETCH;
                end else begin
                    res_status_next = STATUS_MISS;
                    res_idx_next    = '0;
                    res_src_next    = '0;
                    res_gw_next     = '0;
                    res_mtu_next    = '0;
                    res_if_next     = '0;
                    state_next      = ST_DONE;
                end
            end
            ST_FETCH: begin
                res_status_next = STATUS_OK;
                res_idx_next    = HIT_IDX_W'(best_idx_reg);
                res_src_next    = rd_entry.src;
                res_gw_next     = rd_entry.gw;
                res_mtu_next    = rd_entry.mtu;
                res_if_next     = rd_entry.ifindex;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register frees up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {{PAD_W{1'b0}}, res_if_reg, res_mtu_reg,
                                     res_gw_reg, res_src_reg, res_idx_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            entry_cnt_reg <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            entry_cnt_reg <= entry_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_len_reg   <= best_len_next;
        req_addr_reg   <= req_addr_next;
        req_plen_reg   <= req_plen_next;
        req_table_reg  <= req_table_next;
        req_src_reg    <= req_src_next;
        req_gw_reg     <= req_gw_next;
        req_mtu_reg    <= req_mtu_next;
        req_if_reg     <= req_if_next;
        req_usable_reg <= req_usable_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_src_reg    <= res_src_next;
        res_gw_reg     <= res_gw_next;
        res_mtu_reg    <= res_mtu_next;
        res_if_reg     <= res_if_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_cnt_reg <= DEPTH_CNT)
        else $error("route count exceeds table depth");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STATUS_FULL)) |-> (entry_cnt_reg == DEPTH_CNT))
        else $error("insert refused while table has room");

    a_cnt_moves_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (entry_cnt_reg != $past(entry_cnt_reg)) |-> ($past(state_reg) == ST_INS))
        else $error("route count changed outside an insert");
`endif

endmodule
